### rtl/core/csv_column_projector_assert.svh
// Assertion macros for the CSV column projector.
// Used by the top level; the macros expect clk and rst in scope.
`ifndef CSV_COLUMN_PROJECTOR_ASSERT_SVH
`define CSV_COLUMN_PROJECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CSVP_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csv_column_projector: assertion failed");
// Implication into the next cycle.
`define CSVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csv_column_projector: assertion failed");
`else
`define CSVP_ASSERT_IMPLIES(label, ante, cons)
`define CSVP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/csvp_pkg.sv
// Shared types and constants of the CSV column projector.
// No dependencies; used by csvp_cfg and the top level.
`default_nettype none

package csvp_pkg;

  localparam int REG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;
  localparam int SLOTS       = 8;
  localparam int COLUMN_W    = 6;
  localparam int OUT_TDATA_W = 72;

  localparam logic [7:0] NEWLINE       = 8'd10;
  localparam logic [7:0] SEPARATOR_RST = 8'd44;

  localparam logic [REG_IDX_W-1:0] REG_SEPARATOR    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SELECT_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SELECTED     = 2'd2;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_FEW_COLUMNS = 2'd1;
  localparam logic [1:0] ERR_LINE_LONG   = 2'd2;

  // Decoded configuration as the datapath sees it.
  typedef struct packed {
    logic [7:0]                      separator;
    logic [3:0]                      n_eff;
    logic [SLOTS-1:0][COLUMN_W-1:0]  cols;
    logic [COLUMN_W-1:0]             maxcol;
  } cfg_view_t;

endpackage

`default_nettype wire

### rtl/core/csv_column_projector.sv
// CSV column projector: scans text one byte per item, splits lines at the configured
// separator and keeps start and length of each selected column in a small slot RAM.
// At a newline (or end of stream with a partial line open) it emits one descriptor per
// selected slot, or a single error item (nothing when no slot is selected). Ordinary
// bytes are taken in S_SCAN. A separator whose column matches selected slots stalls the
// input in S_CLOSE, as the slot RAM takes one write per cycle. A row end passes through
// S_CLOSE to write matching slots, S_PRIME for the first RAM read and S_EMIT for the
// descriptors or S_ERR for an error item, paced by slot RAM accesses and m_axis_tready.
// Depends on csvp_pkg, csvp_cfg, csvp_ram and csv_column_projector_assert.svh.
`default_nettype none

`include "csv_column_projector_assert.svh"

module csv_column_projector #(
  parameter int MAX_SELECT  = 8,
  parameter int MAX_COLUMNS = 64,
  parameter int LINE_MAX    = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // tdata: data_byte[7:0]; tlast: end_of_stream
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  input  wire logic [7:0]                           s_axis_tdata,
  input  wire logic                                 s_axis_tlast,
  // tdata: row_number[31:0], slot[34:32], column[40:35], start_offset[52:41],
  //        field_length[65:53], is_null[66], zero fill[71:67]
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output      logic [csvp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tuser: error[1:0]; tlast: last
  output      logic [1:0]                           m_axis_tuser,
  output      logic                                 m_axis_tlast,
  input  wire logic                                 cfg_we,
  input  wire logic [csvp_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire logic [csvp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  localparam int POS_W   = $clog2(LINE_MAX + 1);
  localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
  localparam int SLOT_AW = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
  localparam int CNT_W   = SLOT_AW + 1;

  typedef enum logic [4:0] {
    S_SCAN  = 5'b00001,
    S_CLOSE = 5'b00010,
    S_PRIME = 5'b00100,
    S_EMIT  = 5'b01000,
    S_ERR   = 5'b10000
  } state_t;

  csvp_pkg::cfg_view_t view;

  csvp_cfg #(.MAX_SELECT(MAX_SELECT)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .view     (view)
  );

  // Row scan state
  state_t                 state;
  logic [POS_W-1:0]       line_pos;
  logic [POS_W-1:0]       field_start;
  logic [COL_W-1:0]       col_cnt;
  logic [31:0]            row_cnt;
  logic                   line_pending;
  logic                   line_overflow;

  // Pending field close and row finish
  logic [MAX_SELECT-1:0]  close_mask;
  logic [POS_W-1:0]       wr_start;
  logic [POS_W-1:0]       wr_len;
  logic                   fin;
  logic                   fin_emit;
  logic [1:0]             fin_err;
  logic [31:0]            row_out;
  logic [SLOT_AW-1:0]     emit_idx;
  logic [MAX_SELECT-1:0]  slot_valid;
  logic                   rd_valid;

  // Output register
  logic                   out_valid;
  logic [31:0]            o_row;
  logic [2:0]             o_slot;
  logic [5:0]             o_column;
  logic [11:0]            o_start;
  logic [12:0]            o_len;
  logic                   o_null;
  logic [1:0]             o_err;
  logic                   o_last;

  // Slot RAM port
  logic                   ram_we;
  logic [SLOT_AW-1:0]     ram_waddr;
  logic                   ram_re;
  logic [SLOT_AW-1:0]     ram_raddr;
  logic [2*POS_W-1:0]     ram_rdata;

  csvp_ram #(.WIDTH(2*POS_W), .DEPTH(MAX_SELECT)) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({wr_start, wr_len}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic                   in_acc;
  logic                   eos;
  logic [7:0]             in_byte;
  logic                   at_limit;
  logic                   do_finish;
  logic                   is_sep;
  logic                   few_cols;
  logic [MAX_SELECT-1:0]  match_mask;
  logic [MAX_SELECT-1:0]  close_mask_next;
  logic                   out_load_ok;
  logic                   emit_last;
  logic [POS_W-1:0]       rd_start;
  logic [POS_W-1:0]       rd_len;
  logic                   rd_null;

  always_comb begin
    s_axis_tready = (state == S_SCAN);
    in_acc        = s_axis_tvalid && s_axis_tready;
    eos           = s_axis_tlast;
    in_byte       = s_axis_tdata;
    at_limit      = (32'(line_pos) >= LINE_MAX);
    do_finish     = eos ? line_pending : (in_byte == csvp_pkg::NEWLINE);
    is_sep        = !eos && (in_byte != csvp_pkg::NEWLINE) && !at_limit &&
                    (in_byte == view.separator);
    few_cols      = (32'(view.maxcol) >= MAX_COLUMNS) || (32'(view.maxcol) > 32'(col_cnt));
    for (int s = 0; s < MAX_SELECT; s++) begin
      match_mask[s] = (4'(s) < view.n_eff) && !line_overflow &&
                      (32'(col_cnt) < MAX_COLUMNS) &&
                      (32'(view.cols[s]) == 32'(col_cnt));
    end
    // Lowest pending slot gets the write port
    ram_waddr = '0;
    for (int s = MAX_SELECT - 1; s >= 0; s--) begin
      if (close_mask[s]) begin
        ram_waddr = SLOT_AW'(s);
      end
    end
    close_mask_next = close_mask & (close_mask - 1'b1);
    ram_we          = (state == S_CLOSE) && (close_mask != '0);
    out_load_ok     = !out_valid || m_axis_tready;
    emit_last       = ((CNT_W'(emit_idx) + 1'b1) == CNT_W'(view.n_eff));
    ram_re          = (state == S_PRIME) || ((state == S_EMIT) && out_load_ok && !emit_last);
    ram_raddr       = (state == S_PRIME) ? '0 : emit_idx + 1'b1;
    // A slot never written since reset reads as zero
    rd_start        = rd_valid ? ram_rdata[2*POS_W-1:POS_W] : '0;
    rd_len          = rd_valid ? ram_rdata[POS_W-1:0] : '0;
    rd_null         = (rd_len == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SCAN;
      line_pos      <= '0;
      field_start   <= '0;
      col_cnt       <= '0;
      row_cnt       <= '0;
      line_pending  <= 1'b0;
      line_overflow <= 1'b0;
      close_mask    <= '0;
      fin           <= 1'b0;
      fin_emit      <= 1'b0;
      fin_err       <= csvp_pkg::ERR_NONE;
      emit_idx      <= '0;
      slot_valid    <= '0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid <= slot_valid[ram_raddr];
      end

      unique case (state)
        S_SCAN: begin
          if (in_acc && !(eos && !line_pending)) begin
            if (do_finish) begin
              close_mask <= match_mask;
              fin        <= 1'b1;
              fin_emit   <= (view.n_eff != '0);
              if (line_overflow) begin
                fin_err <= csvp_pkg::ERR_LINE_LONG;
              end else if (few_cols) begin
                fin_err <= csvp_pkg::ERR_FEW_COLUMNS;
              end else begin
                fin_err <= csvp_pkg::ERR_NONE;
              end
              row_cnt       <= row_cnt + 1'b1;
              line_pos      <= '0;
              field_start   <= '0;
              col_cnt       <= '0;
              line_pending  <= 1'b0;
              line_overflow <= 1'b0;
              state         <= S_CLOSE;
            end else begin
              line_pending <= 1'b1;
              if (at_limit) begin
                line_overflow <= 1'b1;
              end else begin
                line_pos <= line_pos + 1'b1;
                if (is_sep) begin
                  close_mask  <= match_mask;
                  fin         <= 1'b0;
                  field_start <= line_pos + 1'b1;
                  if (32'(col_cnt) < MAX_COLUMNS) begin
                    col_cnt <= col_cnt + 1'b1;
                  end
                  if (match_mask != '0) begin
                    state <= S_CLOSE;
                  end
                end
              end
            end
          end
        end
        S_CLOSE: begin
          close_mask <= close_mask_next;
          if (close_mask_next == '0) begin
            if (!fin || !fin_emit) begin
              state <= S_SCAN;
            end else if (fin_err != csvp_pkg::ERR_NONE) begin
              state <= S_ERR;
            end else begin
              state <= S_PRIME;
            end
          end
        end
        S_PRIME: begin
          emit_idx <= '0;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load_ok) begin
            out_valid <= 1'b1;
            emit_idx  <= emit_idx + 1'b1;
            if (emit_last) begin
              state <= S_SCAN;
            end
          end
        end
        S_ERR: begin
          if (out_load_ok) begin
            out_valid <= 1'b1;
            state     <= S_SCAN;
          end
        end
        default: state <= S_SCAN;
      endcase
    end
  end

  // Capture write data and row number; load the output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      wr_start <= field_start;
      wr_len   <= line_pos - field_start;
      if (do_finish) begin
        row_out <= row_cnt;
      end
    end
    if (state == S_EMIT && out_load_ok) begin
      o_row    <= row_out;
      o_slot   <= 3'(emit_idx);
      o_column <= view.cols[emit_idx];
      o_start  <= rd_null ? 12'd0 : 12'(rd_start);
      o_len    <= 13'(rd_len);
      o_null   <= rd_null;
      o_err    <= csvp_pkg::ERR_NONE;
      o_last   <= emit_last;
    end else if (state == S_ERR && out_load_ok) begin
      o_row    <= row_out;
      o_slot   <= '0;
      o_column <= (fin_err == csvp_pkg::ERR_FEW_COLUMNS) ? view.maxcol : '0;
      o_start  <= '0;
      o_len    <= '0;
      o_null   <= 1'b0;
      o_err    <= fin_err;
      o_last   <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, o_null, o_len, o_start, o_column, o_slot, o_row};
  assign m_axis_tuser  = o_err;
  assign m_axis_tlast  = o_last;

  `CSVP_ASSERT_IMPLIES(a_err_is_last, m_axis_tvalid && (m_axis_tuser != csvp_pkg::ERR_NONE), m_axis_tlast)
  `CSVP_ASSERT_IMPLIES(a_ram_one_port, ram_we, !ram_re)
  `CSVP_ASSERT_NEXT(a_row_end_stalls, in_acc && !eos && (in_byte == csvp_pkg::NEWLINE), !s_axis_tready)

endmodule

`default_nettype wire

### rtl/core/csvp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module csvp_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 8
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr,
  output      logic [WIDTH-1:0]       rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/csvp_cfg.sv
// Configuration registers of the CSV column projector and their decoded view.
// Depends on csvp_pkg.
`default_nettype none

module csvp_cfg #(
  parameter int MAX_SELECT = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [csvp_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [csvp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output      csvp_pkg::cfg_view_t                 view
);
  logic [7:0]                        separator;
  logic [3:0]                        select_count;
  logic [csvp_pkg::CFG_DATA_W-1:0]   selected_columns;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator        <= csvp_pkg::SEPARATOR_RST;
      select_count     <= '0;
      selected_columns <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csvp_pkg::REG_SEPARATOR:    separator        <= cfg_data[7:0];
        csvp_pkg::REG_SELECT_COUNT: select_count     <= cfg_data[3:0];
        csvp_pkg::REG_SELECTED:     selected_columns <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [3:0] n;
    logic [csvp_pkg::COLUMN_W-1:0] mx;
    n  = (select_count > 4'(MAX_SELECT)) ? 4'(MAX_SELECT) : select_count;
    mx = '0;
    for (int s = 0; s < csvp_pkg::SLOTS; s++) begin
      if (4'(s) < n && selected_columns[csvp_pkg::COLUMN_W*s +: csvp_pkg::COLUMN_W] > mx) begin
        mx = selected_columns[csvp_pkg::COLUMN_W*s +: csvp_pkg::COLUMN_W];
      end
    end
    view.separator = separator;
    view.n_eff     = n;
    view.cols      = selected_columns;
    view.maxcol    = mx;
  end

endmodule

`default_nettype wire
